/* hw/rtl/rsr_pkg.sv */
// Shared types and constants of the Rodrigues symmetry reduction block.
package rsr_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int DIST_W          = 59;
  localparam int THRESH_INT      = 100000000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic last;
    logic skip;
  } rsr_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_FIX,
    BK_SQ,
    BK_CMP,
    BK_FINISH
  } rsr_bk_state_t;

endpackage

/* hw/rtl/rsr_in_if.sv */
// Input channel: one orientation, one symmetry operator and the last flag.
interface rsr_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] orient_x;
  logic signed [W-1:0] orient_y;
  logic signed [W-1:0] orient_z;
  logic signed [W-1:0] sym_x;
  logic signed [W-1:0] sym_y;
  logic signed [W-1:0] sym_z;
  logic                last_operator;

  modport source (output valid, orient_x, orient_y, orient_z, sym_x, sym_y, sym_z,
                  last_operator, input ready);
  modport sink (input valid, orient_x, orient_y, orient_z, sym_x, sym_y, sym_z,
                last_operator, output ready);
endinterface

/* hw/rtl/rsr_out_if.sv */
// Output channel: the reduced vector, its squared length and the found flag.
interface rsr_out_if #(parameter int W = 32, parameter int DW = 59);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] near_x;
  logic signed [W-1:0] near_y;
  logic signed [W-1:0] near_z;
  logic [DW-1:0]       min_dist_sq;
  logic                found;

  modport source (output valid, near_x, near_y, near_z, min_dist_sq, found, input ready);
  modport sink (input valid, near_x, near_y, near_z, min_dist_sq, found, output ready);
endinterface

/* hw/rtl/rsr_front.sv */
// Front end: takes requests, forms the cross products, numerators and denominator.
module rsr_front
  import rsr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int XW          = 72
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_WIDTH-1:0] rx,
  input  logic signed [VALUE_WIDTH-1:0] ry,
  input  logic signed [VALUE_WIDTH-1:0] rz,
  input  logic signed [VALUE_WIDTH-1:0] sx,
  input  logic signed [VALUE_WIDTH-1:0] sy,
  input  logic signed [VALUE_WIDTH-1:0] sz,
  input  logic                         last_in,
  input  logic                         q_full,
  output logic                         push,
  output logic [4*XW-1:0]              push_data,
  output rsr_ctl_t                     push_ctl
);
  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam logic signed [XW-1:0] ONE = XW'(1) <<< (2 * FRAC_BITS);

  logic                 a_valid;
  logic                 a_last;
  logic signed [PW-1:0] p11, p22, p33, p32, p23, p13, p31, p21, p12;
  logic signed [W:0]    sum_x, sum_y, sum_z;
  logic signed [XW-1:0] dot, den, n1, n2, n3;

  assign in_ready = !a_valid || !q_full;
  assign push     = a_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_last <= last_in;
      p11 <= rx * sx;
      p22 <= ry * sy;
      p33 <= rz * sz;
      p32 <= rz * sy;
      p23 <= ry * sz;
      p13 <= rx * sz;
      p31 <= rz * sx;
      p21 <= ry * sx;
      p12 <= rx * sy;
      sum_x <= (W+1)'(rx) + (W+1)'(sx);
      sum_y <= (W+1)'(ry) + (W+1)'(sy);
      sum_z <= (W+1)'(rz) + (W+1)'(sz);
    end
  end

  always_comb begin
    dot = XW'(p11) + XW'(p22) + XW'(p33);
    den = ONE - dot;
    n1  = (XW'(sum_x) <<< FRAC_BITS) - (XW'(p32) - XW'(p23));
    n2  = (XW'(sum_y) <<< FRAC_BITS) - (XW'(p13) - XW'(p31));
    n3  = (XW'(sum_z) <<< FRAC_BITS) - (XW'(p21) - XW'(p12));
    push_data     = {den, n3, n2, n1};
    push_ctl.last = a_last;
    push_ctl.skip = (den == '0);
  end
endmodule

/* hw/rtl/rsr_queue.sv */
// Short queue that decouples the front end from the divide and compare back end.
module rsr_queue
  import rsr_pkg::*;
#(
  parameter int DATA_W = 288,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  rsr_ctl_t          push_ctl,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data,
  output rsr_ctl_t          head_ctl
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_q [DEPTH];
  rsr_ctl_t          ctl_q  [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = data_q[rd_ptr];
  assign head_ctl   = ctl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_q[wr_ptr] <= push_data;
      ctl_q[wr_ptr]  <= push_ctl;
    end
  end
endmodule

/* hw/rtl/rsr_div.sv */
// Radix-2 restoring divider giving a saturated signed fixed-point quotient.
module rsr_div
  import rsr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int XW          = 72
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [XW-1:0]         num,
  input  logic signed [XW-1:0]         den,
  output logic                         busy,
  output logic signed [VALUE_WIDTH-1:0] quo
);
  localparam int W  = VALUE_WIDTH;
  localparam int RW = XW + FRAC_BITS + W;
  localparam int NW = $clog2(W + 1);
  localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  logic [XW-1:0] abs_num, abs_den;
  logic [RW-1:0] rem, dsh;
  logic [W-1:0]  q;
  logic [NW-1:0] cnt;
  logic          neg;

  assign abs_num = num[XW-1] ? XW'(-num) : XW'(num);
  assign abs_den = den[XW-1] ? XW'(-den) : XW'(den);
  assign busy    = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= NW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[XW-1] ^ den[XW-1];
      rem <= RW'(abs_num) << FRAC_BITS;
      dsh <= RW'(abs_den) << (W - 1);
      q   <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[W-2:0], 1'b1};
      end else begin
        q   <= {q[W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // The top quotient bit flags a result outside the signed range.
  always_comb begin
    if (neg) begin
      quo = q[W-1] ? QMIN : -$signed({1'b0, q[W-2:0]});
    end else begin
      quo = q[W-1] ? QMAX : $signed({1'b0, q[W-2:0]});
    end
  end
endmodule

/* hw/rtl/rsr_back.sv */
// Back end: divides, squares, keeps the nearest candidate and emits it per run.
module rsr_back
  import rsr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int XW          = 72
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  logic [4*XW-1:0]               head_data,
  input  rsr_ctl_t                      head_ctl,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_x,
  output logic signed [VALUE_WIDTH-1:0] out_y,
  output logic signed [VALUE_WIDTH-1:0] out_z,
  output logic [DIST_W-1:0]             out_dist,
  output logic                          out_found
);
  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int BA = (PW > 27 + 2 * FRAC_BITS) ? PW : 27 + 2 * FRAC_BITS;
  localparam int BW = BA + 1;
  localparam int CW = (BW > DIST_W) ? BW : DIST_W;
  localparam logic [BW-1:0] THRESH = BW'(THRESH_INT) << (2 * FRAC_BITS);

  rsr_bk_state_t state, state_next;
  logic                 div_start;
  logic                 busy_x, busy_y, busy_z;
  logic signed [W-1:0]  quo_x, quo_y, quo_z;
  logic signed [W-1:0]  c_x, c_y, c_z;
  logic signed [PW-1:0] sq_x, sq_y, sq_z;
  logic [BW-1:0]        dist_sum;
  logic [BW-1:0]        best_dist;
  logic signed [W-1:0]  best_x, best_y, best_z;
  logic                 have_best;
  logic                 fin_go;

  rsr_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .XW(XW)) u_div_x (
    .clk, .rst, .start(div_start), .num(head_data[XW-1:0]),
    .den(head_data[4*XW-1:3*XW]), .busy(busy_x), .quo(quo_x)
  );
  rsr_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .XW(XW)) u_div_y (
    .clk, .rst, .start(div_start), .num(head_data[2*XW-1:XW]),
    .den(head_data[4*XW-1:3*XW]), .busy(busy_y), .quo(quo_y)
  );
  rsr_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .XW(XW)) u_div_z (
    .clk, .rst, .start(div_start), .num(head_data[3*XW-1:2*XW]),
    .den(head_data[4*XW-1:3*XW]), .busy(busy_z), .quo(quo_z)
  );

  assign dist_sum = BW'($unsigned(sq_x)) + BW'($unsigned(sq_y)) + BW'($unsigned(sq_z));
  assign fin_go   = !head_ctl.last || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          state_next = head_ctl.skip ? BK_FINISH : BK_LOAD;
        end
      end
      BK_LOAD: begin
        div_start  = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (!busy_x && !busy_y && !busy_z) begin
          state_next = BK_FIX;
        end
      end
      BK_FIX:  state_next = BK_SQ;
      BK_SQ:   state_next = BK_CMP;
      BK_CMP:  state_next = BK_FINISH;
      BK_FINISH: begin
        if (fin_go) begin
          pop        = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == BK_FIX) begin
      c_x <= quo_x;
      c_y <= quo_y;
      c_z <= quo_z;
    end
    if (state == BK_SQ) begin
      sq_x <= c_x * c_x;
      sq_y <= c_y * c_y;
      sq_z <= c_z * c_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_dist <= THRESH;
      best_x    <= '0;
      best_y    <= '0;
      best_z    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == BK_CMP && dist_sum < best_dist) begin
        have_best <= 1'b1;
        best_dist <= dist_sum;
        best_x    <= c_x;
        best_y    <= c_y;
        best_z    <= c_z;
      end
      if (state == BK_FINISH && fin_go && head_ctl.last) begin
        out_valid <= 1'b1;
        have_best <= 1'b0;
        best_dist <= THRESH;
        best_x    <= '0;
        best_y    <= '0;
        best_z    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_FINISH && fin_go && head_ctl.last) begin
      out_x     <= best_x;
      out_y     <= best_y;
      out_z     <= best_z;
      out_found <= have_best;
      if (!have_best) begin
        out_dist <= '0;
      end else if (CW'(best_dist) > CW'(DIST_MAX)) begin
        out_dist <= DIST_MAX;
      end else begin
        out_dist <= DIST_W'(best_dist);
      end
    end
  end

  a_no_best_is_clear: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> best_dist == THRESH && best_x == '0 && best_z == '0)
    else $error("running state not clear without a candidate");
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_dist == '0 && out_x == '0 && out_y == '0)
    else $error("result without a candidate is not zero");
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> head_valid)
    else $error("queue head lost while operator in flight");
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    pop && head_ctl.last |=> !have_best && out_valid)
    else $error("run end did not emit and clear");
endmodule

/* hw/rtl/rodrigues_symmetry_reduce_core.sv */
// Top level of the Rodrigues vector symmetry reduction block.
// Each request carries an orientation and one symmetry operator; the block composes them,
// keeps the composed vector of smallest squared length below 1e8 and, on the request
// flagged last_operator, returns that vector, its Q27.32 squared length and a found flag.
// An operator whose denominator is zero is skipped. The back end finishes one request
// before it takes the next; its three radix-2 divider lanes retire one quotient bit per
// cycle. A two-entry queue lets the front end take the next requests meanwhile, and the
// output register holds a result until taken.
module rodrigues_symmetry_reduce_core
  import rsr_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rsr_in_if.sink   in_ch,
  rsr_out_if.source out_ch
);
  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W;
  localparam int XA = (PW > W + FRAC_BITS + 1) ? PW : W + FRAC_BITS + 1;
  localparam int XW = ((XA > 2 * FRAC_BITS + 1) ? XA : 2 * FRAC_BITS + 1) + 4;

  logic            push, pop, q_full, head_valid;
  logic [4*XW-1:0] push_data, head_data;
  rsr_ctl_t        push_ctl, head_ctl;

  rsr_front #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .XW(XW)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .rx(in_ch.orient_x), .ry(in_ch.orient_y), .rz(in_ch.orient_z),
    .sx(in_ch.sym_x), .sy(in_ch.sym_y), .sz(in_ch.sym_z),
    .last_in(in_ch.last_operator),
    .q_full, .push, .push_data, .push_ctl
  );

  rsr_queue #(.DATA_W(4 * XW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_data, .push_ctl, .full(q_full),
    .pop, .head_valid, .head_data, .head_ctl
  );

  rsr_back #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .XW(XW)) u_back (
    .clk, .rst, .head_valid, .head_data, .head_ctl, .pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_x(out_ch.near_x), .out_y(out_ch.near_y), .out_z(out_ch.near_z),
    .out_dist(out_ch.min_dist_sq), .out_found(out_ch.found)
  );
endmodule
